// File: sv/assert_macros.svh
// assertion macros used by the top-level rtl file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled while in reset
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: sv/cnpm_pkg.sv
// types and constants for the netspec parser and prefix matcher
// no dependencies
package cnpm_pkg;

    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 48;

    typedef enum logic [1:0] {
        PH_ADDR   = 2'd0,
        PH_SLASH  = 2'd1,
        PH_DIGITS = 2'd2,
        PH_DONE   = 2'd3
    } phase_t;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_OCTET   = 3'd1;
    localparam logic [2:0] ST_MANY    = 3'd2;
    localparam logic [2:0] ST_BADSYM  = 3'd3;
    localparam logic [2:0] ST_SHORT   = 3'd4;
    localparam logic [2:0] ST_PREFIX  = 3'd5;
    localparam logic [2:0] ST_WILD    = 3'd6;
    localparam logic [2:0] ST_NEG     = 3'd7;

    localparam logic [7:0] CH_NUL   = 8'd0;
    localparam logic [7:0] CH_DOT   = 8'd46;
    localparam logic [7:0] CH_SLASH = 8'd47;
    localparam logic [7:0] CH_PLUS  = 8'd43;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_CR    = 8'd13;

    localparam logic [6:0] PREFIX_SAT = 7'd127;

    typedef struct packed {
        logic [1:0]  octet_index;
        logic [7:0]  octet_acc;
        logic        digit_seen;
        logic [23:0] stored_octets;
        logic [6:0]  prefix_acc;
        logic        prefix_given;
        logic [2:0]  error_code;
    } parse_state_t;

endpackage

// File: sv/cnpm_parser.sv
// character-level parser state for the netspec string
// depends on cnpm_pkg
module cnpm_parser (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  step_valid,
    input  logic [7:0]            step_char,
    output cnpm_pkg::parse_state_t state
);
    import cnpm_pkg::*;

    phase_t       phase_reg, phase_next;
    parse_state_t st_reg, st_next;

    logic        is_digit, is_space, active;
    logic [3:0]  digit;
    logic [11:0] octet_val;
    logic [10:0] prefix_val;
    logic [6:0]  prefix_sat;

    always_comb begin
        is_digit   = step_char inside {[CH_ZERO:CH_NINE]};
        is_space   = (step_char == CH_SPACE) || (step_char inside {[CH_TAB:CH_CR]});
        digit      = 4'(step_char - CH_ZERO);
        octet_val  = {1'b0, st_reg.octet_acc, 3'b000} + {3'b000, st_reg.octet_acc, 1'b0}
                     + {8'd0, digit};
        prefix_val = {1'b0, st_reg.prefix_acc, 3'b000} + {3'b000, st_reg.prefix_acc, 1'b0}
                     + {7'd0, digit};
        prefix_sat = (prefix_val > {4'd0, PREFIX_SAT}) ? PREFIX_SAT : prefix_val[6:0];
        active     = step_valid && (step_char != CH_NUL) && (st_reg.error_code == ST_OK);
    end

    // phase transitions
    always_comb begin
        phase_next = phase_reg;
        if (step_valid && step_char == CH_NUL) begin
            phase_next = PH_ADDR;
        end else if (active) begin
            case (phase_reg)
                PH_ADDR: begin
                    if (step_char == CH_SLASH) phase_next = PH_SLASH;
                end
                PH_SLASH: begin
                    if (is_space) phase_next = PH_SLASH;
                    else if (step_char == CH_PLUS || is_digit) phase_next = PH_DIGITS;
                    else phase_next = PH_DONE;
                end
                PH_DIGITS: begin
                    if (!is_digit) phase_next = PH_DONE;
                end
                PH_DONE: phase_next = PH_DONE;
                default: phase_next = PH_ADDR;
            endcase
        end
    end

    // datapath
    always_comb begin
        st_next = st_reg;
        if (step_valid && step_char == CH_NUL) begin
            st_next = '0;
        end else if (active) begin
            case (phase_reg)
                PH_ADDR: begin
                    if (is_digit) begin
                        if (octet_val > 12'd255) begin
                            st_next.error_code = ST_OCTET;
                        end else begin
                            st_next.octet_acc  = octet_val[7:0];
                            st_next.digit_seen = 1'b1;
                        end
                    end else if (step_char == CH_DOT) begin
                        if (st_reg.octet_index != 2'd3) begin
                            if (!st_reg.digit_seen) begin
                                st_next.error_code = ST_BADSYM;
                            end else begin
                                st_next.stored_octets = {st_reg.stored_octets[15:0],
                                                         st_reg.octet_acc};
                                st_next.octet_acc     = '0;
                                st_next.digit_seen    = 1'b0;
                                st_next.octet_index   = st_reg.octet_index + 2'd1;
                            end
                        end else begin
                            st_next.error_code = ST_MANY;
                        end
                    end else if (step_char == CH_SLASH) begin
                        st_next.prefix_given = 1'b1;
                    end else begin
                        st_next.error_code = ST_BADSYM;
                    end
                end
                PH_SLASH: begin
                    if (!is_space && step_char == CH_MINUS) st_next.error_code = ST_NEG;
                    else if (is_digit) st_next.prefix_acc = prefix_sat;
                end
                PH_DIGITS: begin
                    if (is_digit) st_next.prefix_acc = prefix_sat;
                end
                PH_DONE: st_next = st_reg;
                default: st_next = st_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_ADDR;
            st_reg    <= '0;
        end else begin
            phase_reg <= phase_next;
            st_reg    <= st_next;
        end
    end

    assign state = st_reg;

endmodule

// File: sv/cnpm_result.sv
// end-of-string evaluation and the result word register
// depends on cnpm_pkg
module cnpm_result (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   load,
    input  cnpm_pkg::parse_state_t state,
    input  logic [31:0]            test_address,
    input  logic                   mask_net,
    output logic                   out_free,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // matched[0], status[3:1], prefix_length[9:4], network_address[41:10], zero pad
    output logic [cnpm_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import cnpm_pkg::*;

    logic [2:0]  status;
    logic [31:0] net, mask;
    logic [6:0]  bits;
    logic [7:0]  first;
    logic        ok, matched;
    logic [5:0]  shamt;

    logic        valid_reg, valid_next;
    logic [OUT_TDATA_W-1:0] data_reg, data_next;

    always_comb begin
        net   = {state.stored_octets, state.octet_acc};
        first = state.stored_octets[23:16];
        if (state.prefix_given) bits = state.prefix_acc;
        else if (first >= 8'd240) bits = 7'd32;
        else if (first >= 8'd224) bits = 7'd4;
        else if (first >= 8'd192) bits = 7'd24;
        else if (first >= 8'd128) bits = 7'd16;
        else bits = 7'd8;

        status = state.error_code;
        if ((status == ST_OK || status == ST_NEG)
            && (state.octet_index != 2'd3 || !state.digit_seen)) begin
            status = ST_SHORT;
        end
        if (status == ST_OK) begin
            if (bits[6:3] > 4'd4) status = ST_MANY;
            else if (bits > 7'd32) status = ST_PREFIX;
            else if (bits == 7'd0 && net != 32'd0) status = ST_WILD;
        end
        ok      = (status == ST_OK);
        shamt   = 6'd32 - bits[5:0];
        mask    = 32'hFFFF_FFFF << shamt;
        matched = ok && ((test_address & mask) == (mask_net ? (net & mask) : net));
    end

    assign out_free = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg && !m_tready;
        data_next  = data_reg;
        if (load) begin
            valid_next = 1'b1;
            data_next  = {6'd0, (ok ? net : 32'd0), (ok ? bits[5:0] : 6'd0), status, matched};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) valid_reg <= 1'b0;
        else          valid_reg <= valid_next;
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

endmodule

// File: sv/cidr_netspec_parse_match_top.sv
// top level: input word register, netspec parser and result register
// depends on cnpm_pkg, cnpm_parser, cnpm_result, assert_macros.svh
// timing: a word is registered on accept and parsed from that register, a nul word
// only once the result register is free; its result is loaded there and shows on m_tvalid
// throughput: one word per cycle, stalls only while the result register is full
// reset: aresetn synchronous active low clears parser state and both valid flags
`include "assert_macros.svh"

module cidr_netspec_parse_match_top (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    // character[7:0], test_address[39:8], mask_net[40], zero pad
    input  logic [cnpm_pkg::IN_TDATA_W-1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // matched[0], status[3:1], prefix_length[9:4], network_address[41:10], zero pad
    output logic [cnpm_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import cnpm_pkg::*;

    logic        in_valid_reg, in_valid_next;
    logic [7:0]  char_reg;
    logic [31:0] addr_reg;
    logic        mnet_reg;
    logic        out_free, advance, load;
    parse_state_t pstate;

    assign advance  = in_valid_reg && ((char_reg != CH_NUL) || out_free);
    assign load     = advance && (char_reg == CH_NUL);
    assign s_tready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tready) in_valid_next = s_tvalid;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) in_valid_reg <= 1'b0;
        else          in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            char_reg <= s_tdata[7:0];
            addr_reg <= s_tdata[39:8];
            mnet_reg <= s_tdata[40];
        end
    end

    cnpm_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step_valid (advance),
        .step_char  (char_reg),
        .state      (pstate)
    );

    cnpm_result u_result (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .load         (load),
        .state        (pstate),
        .test_address (addr_reg),
        .mask_net     (mnet_reg),
        .out_free     (out_free),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata)
    );

    `ASSERT_IMPLIES(a_stall_cause, aclk, aresetn, !s_tready,
        in_valid_reg && char_reg == CH_NUL && m_tvalid && !m_tready)
    `ASSERT_IMPLIES(a_err_clears, aclk, aresetn, m_tvalid && m_tdata[3:1] != ST_OK,
        !m_tdata[0] && m_tdata[9:4] == 6'd0 && m_tdata[41:10] == 32'd0)
    `ASSERT_IMPLIES(a_prefix_range, aclk, aresetn, m_tvalid, m_tdata[9:4] <= 6'd32)
    `ASSERT_NEXT(a_nul_resets, aclk, aresetn, load,
        pstate.error_code == ST_OK && !pstate.prefix_given && pstate.octet_index == 2'd0)

endmodule

// File: tb/sv/cnpm_checker.sv
`timescale 1ns / 100ps
// checker for the netspec parser and prefix matcher: watches both stream channels,
// predicts each result word from the accepted characters and compares it field by field
// depends on cnpm_pkg
module cnpm_netspec_checker
    import cnpm_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [OUT_TDATA_W-1:0] m_tdata,
    output int                     fail_count,
    output int                     pending,
    output int                     results_checked,
    output logic [7:0]             statuses_seen
);

    typedef struct packed {
        logic        matched;
        logic [2:0]  status;
        logic [5:0]  plen;
        logic [31:0] net_addr;
    } verdict_t;

    verdict_t expected_verdicts[$];
    verdict_t want;

    logic [1:0]  oct_idx;
    logic [7:0]  oct_acc;
    logic        dig_seen;
    logic [23:0] octets;
    phase_t      phase;
    logic [6:0]  pfx_acc;
    logic        pfx_given;
    logic [2:0]  err_code;

    function automatic logic is_digit(input logic [7:0] ch);
        return ch >= CH_ZERO && ch <= CH_NINE;
    endfunction

    function automatic logic is_space(input logic [7:0] ch);
        return ch == CH_SPACE || (ch >= CH_TAB && ch <= CH_CR);
    endfunction

    function automatic logic [6:0] prefix_push_digit(input logic [6:0] acc, input logic [7:0] ch);
        int v;
        v = int'(acc) * 10 + int'(ch - CH_ZERO);
        return (v > int'(PREFIX_SAT)) ? PREFIX_SAT : v[6:0];
    endfunction

    task automatic clear_parser();
        oct_idx   = '0;
        oct_acc   = '0;
        dig_seen  = 1'b0;
        octets    = '0;
        phase     = PH_ADDR;
        pfx_acc   = '0;
        pfx_given = 1'b0;
        err_code  = ST_OK;
    endtask

    task automatic apply_netspec_char(input logic [7:0] ch, input logic [31:0] addr,
                                      input logic mnet);
        verdict_t    v;
        logic [2:0]  st;
        logic [31:0] net_val;
        logic [31:0] mask;
        logic [31:0] ref_net;
        int          bits;
        int          acc;
        if (ch != CH_NUL) begin
            if (err_code != ST_OK) begin
                // first error sticks until the terminator
            end else if (phase == PH_ADDR) begin
                if (is_digit(ch)) begin
                    acc = int'(oct_acc) * 10 + int'(ch - CH_ZERO);
                    if (acc > 255) begin
                        err_code = ST_OCTET;
                    end else begin
                        oct_acc  = acc[7:0];
                        dig_seen = 1'b1;
                    end
                end else if (ch == CH_DOT) begin
                    if (oct_idx == 2'd3) begin
                        err_code = ST_MANY;
                    end else if (!dig_seen) begin
                        err_code = ST_BADSYM;
                    end else begin
                        octets   = {octets[15:0], oct_acc};
                        oct_acc  = '0;
                        dig_seen = 1'b0;
                        oct_idx  = oct_idx + 2'd1;
                    end
                end else if (ch == CH_SLASH) begin
                    pfx_given = 1'b1;
                    phase     = PH_SLASH;
                end else begin
                    err_code = ST_BADSYM;
                end
            end else if (phase == PH_SLASH) begin
                if (!is_space(ch)) begin
                    if (ch == CH_PLUS) begin
                        phase = PH_DIGITS;
                    end else if (ch == CH_MINUS) begin
                        err_code = ST_NEG;
                        phase    = PH_DONE;
                    end else if (is_digit(ch)) begin
                        pfx_acc = prefix_push_digit(pfx_acc, ch);
                        phase   = PH_DIGITS;
                    end else begin
                        phase = PH_DONE;
                    end
                end
            end else if (phase == PH_DIGITS) begin
                if (is_digit(ch)) pfx_acc = prefix_push_digit(pfx_acc, ch);
                else phase = PH_DONE;
            end
        end else begin
            st = err_code;
            if ((st == ST_OK || st == ST_NEG) && (oct_idx != 2'd3 || !dig_seen)) st = ST_SHORT;
            net_val = {octets, oct_acc};
            bits    = 0;
            if (st == ST_OK) begin
                if (pfx_given) bits = int'(pfx_acc);
                else if (octets[23:16] >= 8'd240) bits = 32;
                else if (octets[23:16] >= 8'd224) bits = 4;
                else if (octets[23:16] >= 8'd192) bits = 24;
                else if (octets[23:16] >= 8'd128) bits = 16;
                else bits = 8;
                if (bits / 8 > 4) st = ST_MANY;
                else if (bits > 32) st = ST_PREFIX;
                else if (bits == 0 && net_val != 32'd0) st = ST_WILD;
            end
            v.matched = 1'b0;
            if (st == ST_OK) begin
                mask      = (bits == 0) ? 32'd0 : (32'hFFFF_FFFF << (32 - bits));
                ref_net   = mnet ? (net_val & mask) : net_val;
                v.matched = ((addr & mask) == ref_net);
                v.plen    = bits[5:0];
                v.net_addr = net_val;
            end else begin
                v.plen     = '0;
                v.net_addr = '0;
            end
            v.status = st;
            expected_verdicts.push_back(v);
            clear_parser();
        end
    endtask

    task automatic report_mismatch(input string field, input logic [47:0] got,
                                   input logic [47:0] exp_val);
        fail_count++;
        if (fail_count <= 40)
            $display("%0t mismatch on %s: got 0x%0h, expected 0x%0h", $time, field, got, exp_val);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_parser();
            expected_verdicts.delete();
            fail_count      = 0;
            results_checked = 0;
            statuses_seen   = '0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_verdicts.size() == 0) begin
                    report_mismatch("word with nothing pending", m_tdata, '0);
                end else begin
                    want = expected_verdicts.pop_front();
                    if (m_tdata[0] !== want.matched)
                        report_mismatch("matched", m_tdata[0], want.matched);
                    if (m_tdata[3:1] !== want.status)
                        report_mismatch("status", m_tdata[3:1], want.status);
                    if (m_tdata[9:4] !== want.plen)
                        report_mismatch("prefix_length", m_tdata[9:4], want.plen);
                    if (m_tdata[41:10] !== want.net_addr)
                        report_mismatch("network_address", m_tdata[41:10], want.net_addr);
                    results_checked++;
                    statuses_seen[want.status] = 1'b1;
                end
            end
            if (s_tvalid && s_tready)
                apply_netspec_char(s_tdata[7:0], s_tdata[39:8], s_tdata[40]);
        end
        pending = expected_verdicts.size();
    end

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// testbench top for the netspec parser and prefix matcher: clock, reset, netspec strings
// sent a character per word with bursty timing, a stalling receiver and the verdict
// depends on cnpm_pkg, cidr_netspec_parse_match_top, cnpm_netspec_checker
module tb;
    import cnpm_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int TARGET_CHARS = 950;
    localparam int TAIL_CYCLES  = 8;
    localparam int CLASS_EDGES [8] = '{127, 128, 191, 192, 223, 224, 239, 240};

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_RANDOM,
        RX_RUNS
    } rx_mode_t;

    logic                   aclk;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    int         fail_count;
    int         pending;
    int         results_checked;
    logic [7:0] statuses_seen;

    int         cycle_count = 0;
    int         burst_left  = 0;
    int         chars_sent  = 0;
    int         strings_sent = 0;
    logic [7:0] text[$];

    rx_mode_t   rx_mode    = RX_OPEN;
    logic [7:0] mode_timer = '0;
    int         run_left   = 0;
    logic       run_level  = 1'b0;

    cidr_netspec_parse_match_top DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    cnpm_netspec_checker checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .fail_count      (fail_count),
        .pending         (pending),
        .results_checked (results_checked),
        .statuses_seen   (statuses_seen)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycle_count, pending);
            $display("status: fail");
            $finish;
        end
    end

    // receiver: open, random, or long runs of stall and accept
    always @(negedge aclk) begin
        mode_timer = mode_timer + 8'd1;
        if (mode_timer == 8'd0) rx_mode = rx_mode_t'($urandom_range(0, 2));
        case (rx_mode)
            RX_OPEN: begin
                m_tready <= 1'b1;
            end
            RX_RANDOM: begin
                m_tready <= ($urandom_range(0, 3) != 0);
            end
            default: begin
                if (run_left == 0) begin
                    run_level = ~run_level;
                    run_left  = $urandom_range(1, 12);
                end
                run_left--;
                m_tready <= run_level;
            end
        endcase
    end

    // called at a falling edge, returns at the falling edge after the word is taken
    task automatic send_word(input logic [7:0] ch, input logic [31:0] addr, input logic mnet);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 24);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, mnet, addr, ch};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        burst_left--;
        chars_sent++;
    endtask

    // text body with junk address fields, then the terminator carrying the real ones
    task automatic send_text(input logic [31:0] addr, input logic mnet);
        foreach (text[i]) send_word(text[i], $urandom, 1'($urandom_range(0, 1)));
        send_word(CH_NUL, addr, mnet);
        strings_sent++;
    endtask

    task automatic load_string(input string s);
        text.delete();
        for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
    endtask

    task automatic append_dec(input int value, input int zeros);
        string s;
        s = $sformatf("%0d", value);
        repeat (zeros) text.push_back(CH_ZERO);
        for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
    endtask

    initial begin
        int          n_octets;
        int          oct[6];
        int          plen;
        int          eff_len;
        int          pos;
        int          w;
        bit          has_slash;
        logic [31:0] net_val;
        logic [31:0] mask;
        logic [31:0] addr;

        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // wildcard net of all zeros, class inferred from a top octet, overflow, empty
        load_string("0.0.0.0/0");
        send_text(32'hFFFF_FFFF, 1'b1);
        load_string("255.9.9.9");
        send_text(32'hFF09_0909, 1'b0);
        load_string("256");
        send_text(32'h0000_0000, 1'b1);
        text.delete();
        send_text(32'h8000_0001, 1'b0);

        while (chars_sent < TARGET_CHARS) begin
            text.delete();
            n_octets = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 6) : 4;
            for (int i = 0; i < 6; i++) begin
                case ($urandom_range(0, 7))
                    0: oct[i] = 0;
                    1: oct[i] = 255;
                    2: oct[i] = $urandom_range(0, 9);
                    default: oct[i] = $urandom_range(0, 255);
                endcase
            end
            if ($urandom_range(0, 2) == 0) oct[0] = CLASS_EDGES[$urandom_range(0, 7)];
            has_slash = ($urandom_range(0, 9) < 6);
            case ($urandom_range(0, 9))
                6: plen = 0;
                7: plen = 32;
                8: plen = $urandom_range(33, 45);
                9: plen = $urandom_range(46, 999);
                default: plen = $urandom_range(0, 32);
            endcase
            if (has_slash) eff_len = plen;
            else if (oct[0] >= 240) eff_len = 32;
            else if (oct[0] >= 224) eff_len = 4;
            else if (oct[0] >= 192) eff_len = 24;
            else if (oct[0] >= 128) eff_len = 16;
            else eff_len = 8;
            if (eff_len > 32) mask = 32'hFFFF_FFFF;
            else if (eff_len == 0) mask = 32'd0;
            else mask = 32'hFFFF_FFFF << (32 - eff_len);
            net_val = {oct[0][7:0], oct[1][7:0], oct[2][7:0], oct[3][7:0]};
            // keep host bits clear often enough to reach the match and wildcard-ok paths
            if ($urandom_range(0, 2) == 0) begin
                net_val = net_val & mask;
                for (int i = 0; i < 4; i++) oct[i] = int'(net_val[31 - 8 * i -: 8]);
            end

            for (int i = 0; i < n_octets; i++) begin
                if (i > 0) text.push_back(CH_DOT);
                append_dec(oct[i], ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0);
            end
            if (has_slash) begin
                text.push_back(CH_SLASH);
                repeat ($urandom_range(0, 2)) begin
                    w = $urandom_range(8, 13);
                    text.push_back((w == 8) ? CH_SPACE : 8'(w));
                end
                case ($urandom_range(0, 19))
                    0, 1, 2, 3: text.push_back(CH_PLUS);
                    4: text.push_back(CH_MINUS);
                    default: ;
                endcase
                if ($urandom_range(0, 19) != 0) append_dec(plen, 0);
                if ($urandom_range(0, 4) == 0)
                    repeat ($urandom_range(1, 3)) text.push_back(8'($urandom_range(1, 255)));
            end

            // broken strings: one corrupted, dropped or extra character
            if ($urandom_range(0, 4) == 0 && text.size() > 0) begin
                pos = $urandom_range(0, text.size() - 1);
                case ($urandom_range(0, 4))
                    0: text[pos] = 8'($urandom_range(1, 255));
                    1: text.delete(pos);
                    2: text.insert(pos, 8'($urandom_range(1, 255)));
                    3: text.insert(pos, CH_DOT);
                    default: text.insert(pos, CH_MINUS);
                endcase
            end
            if ($urandom_range(0, 29) == 0) text.delete();

            if ($urandom_range(0, 1) == 0) addr = net_val ^ ($urandom & ~mask);
            else addr = $urandom;
            send_text(addr, 1'($urandom_range(0, 1)));
        end

        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("covered %0d netspec strings over %0d characters, %0d results checked",
                 strings_sent, chars_sent, results_checked);
        $display("status codes seen, one bit per code from 7 down to 0: %b", statuses_seen);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("status: fail");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+sv
sv/cnpm_pkg.sv
sv/cnpm_parser.sv
sv/cnpm_result.sv
sv/cidr_netspec_parse_match_top.sv
tb/sv/cnpm_checker.sv
tb/sv/tb.sv
